// ===== rtl/seed_pkg.sv =====
// SEED cipher package: S-box tables, the G function and the sequencer state type.
// Used by seed_block_cipher_unit and seed_g_unit; depends on nothing else.
package seed_pkg;

    localparam int Rounds = 16;
    localparam int RoundBits = $clog2(Rounds);
    localparam int KeyWords = 2 * Rounds;
    localparam int KeyAddrBits = $clog2(KeyWords);
    localparam logic [31:0] KcBase = 32'h9E3779B9;

    localparam logic [0:0] OpEncrypt = 1'b0;
    localparam logic [0:0] OpDecrypt = 1'b1;

    typedef enum logic [2:0] {
        ST_KEYGEN_K0,
        ST_KEYGEN_K1,
        ST_IDLE,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_MIX,
        ST_DONE
    } seq_state_t;

    localparam logic [7:0] Sbox1 [256] = '{
        8'hA9,8'h85,8'hD6,8'hD3,8'h54,8'h1D,8'hAC,8'h25,8'h5D,8'h43,8'h18,8'h1E,8'h51,8'hFC,8'hCA,8'h63,
        8'h28,8'h44,8'h20,8'h9D,8'hE0,8'hE2,8'hC8,8'h17,8'hA5,8'h8F,8'h03,8'h7B,8'hBB,8'h13,8'hD2,8'hEE,
        8'h70,8'h8C,8'h3F,8'hA8,8'h32,8'hDD,8'hF6,8'h74,8'hEC,8'h95,8'h0B,8'h57,8'h5C,8'h5B,8'hBD,8'h01,
        8'h24,8'h1C,8'h73,8'h98,8'h10,8'hCC,8'hF2,8'hD9,8'h2C,8'hE7,8'h72,8'h83,8'h9B,8'hD1,8'h86,8'hC9,
        8'h60,8'h50,8'hA3,8'hEB,8'h0D,8'hB6,8'h9E,8'h4F,8'hB7,8'h5A,8'hC6,8'h78,8'hA6,8'h12,8'hAF,8'hD5,
        8'h61,8'hC3,8'hB4,8'h41,8'h52,8'h7D,8'h8D,8'h08,8'h1F,8'h99,8'h00,8'h19,8'h04,8'h53,8'hF7,8'hE1,
        8'hFD,8'h76,8'h2F,8'h27,8'hB0,8'h8B,8'h0E,8'hAB,8'hA2,8'h6E,8'h93,8'h4D,8'h69,8'h7C,8'h09,8'h0A,
        8'hBF,8'hEF,8'hF3,8'hC5,8'h87,8'h14,8'hFE,8'h64,8'hDE,8'h2E,8'h4B,8'h1A,8'h06,8'h21,8'h6B,8'h66,
        8'h02,8'hF5,8'h92,8'h8A,8'h0C,8'hB3,8'h7E,8'hD0,8'h7A,8'h47,8'h96,8'hE5,8'h26,8'h80,8'hAD,8'hDF,
        8'hA1,8'h30,8'h37,8'hAE,8'h36,8'h15,8'h22,8'h38,8'hF4,8'hA7,8'h45,8'h4C,8'h81,8'hE9,8'h84,8'h97,
        8'h35,8'hCB,8'hCE,8'h3C,8'h71,8'h11,8'hC7,8'h89,8'h75,8'hFB,8'hDA,8'hF8,8'h94,8'h59,8'h82,8'hC4,
        8'hFF,8'h49,8'h39,8'h67,8'hC0,8'hCF,8'hD7,8'hB8,8'h0F,8'h8E,8'h42,8'h23,8'h91,8'h6C,8'hDB,8'hA4,
        8'h34,8'hF1,8'h48,8'hC2,8'h6F,8'h3D,8'h2D,8'h40,8'hBE,8'h3E,8'hBC,8'hC1,8'hAA,8'hBA,8'h4E,8'h55,
        8'h3B,8'hDC,8'h68,8'h7F,8'h9C,8'hD8,8'h4A,8'h56,8'h77,8'hA0,8'hED,8'h46,8'hB5,8'h2B,8'h65,8'hFA,
        8'hE3,8'hB9,8'hB1,8'h9F,8'h5E,8'hF9,8'hE6,8'hB2,8'h31,8'hEA,8'h6D,8'h5F,8'hE4,8'hF0,8'hCD,8'h88,
        8'h16,8'h3A,8'h58,8'hD4,8'h62,8'h29,8'h07,8'h33,8'hE8,8'h1B,8'h05,8'h79,8'h90,8'h6A,8'h2A,8'h9A
    };

    localparam logic [7:0] Sbox2 [256] = '{
        8'h38,8'hE8,8'h2D,8'hA6,8'hCF,8'hDE,8'hB3,8'hB8,8'hAF,8'h60,8'h55,8'hC7,8'h44,8'h6F,8'h6B,8'h5B,
        8'hC3,8'h62,8'h33,8'hB5,8'h29,8'hA0,8'hE2,8'hA7,8'hD3,8'h91,8'h11,8'h06,8'h1C,8'hBC,8'h36,8'h4B,
        8'hEF,8'h88,8'h6C,8'hA8,8'h17,8'hC4,8'h16,8'hF4,8'hC2,8'h45,8'hE1,8'hD6,8'h3F,8'h3D,8'h8E,8'h98,
        8'h28,8'h4E,8'hF6,8'h3E,8'hA5,8'hF9,8'h0D,8'hDF,8'hD8,8'h2B,8'h66,8'h7A,8'h27,8'h2F,8'hF1,8'h72,
        8'h42,8'hD4,8'h41,8'hC0,8'h73,8'h67,8'hAC,8'h8B,8'hF7,8'hAD,8'h80,8'h1F,8'hCA,8'h2C,8'hAA,8'h34,
        8'hD2,8'h0B,8'hEE,8'hE9,8'h5D,8'h94,8'h18,8'hF8,8'h57,8'hAE,8'h08,8'hC5,8'h13,8'hCD,8'h86,8'hB9,
        8'hFF,8'h7D,8'hC1,8'h31,8'hF5,8'h8A,8'h6A,8'hB1,8'hD1,8'h20,8'hD7,8'h02,8'h22,8'h04,8'h68,8'h71,
        8'h07,8'hDB,8'h9D,8'h99,8'h61,8'hBE,8'hE6,8'h59,8'hDD,8'h51,8'h90,8'hDC,8'h9A,8'hA3,8'hAB,8'hD0,
        8'h81,8'h0F,8'h47,8'h1A,8'hE3,8'hEC,8'h8D,8'hBF,8'h96,8'h7B,8'h5C,8'hA2,8'hA1,8'h63,8'h23,8'h4D,
        8'hC8,8'h9E,8'h9C,8'h3A,8'h0C,8'h2E,8'hBA,8'h6E,8'h9F,8'h5A,8'hF2,8'h92,8'hF3,8'h49,8'h78,8'hCC,
        8'h15,8'hFB,8'h70,8'h75,8'h7F,8'h35,8'h10,8'h03,8'h64,8'h6D,8'hC6,8'h74,8'hD5,8'hB4,8'hEA,8'h09,
        8'h76,8'h19,8'hFE,8'h40,8'h12,8'hE0,8'hBD,8'h05,8'hFA,8'h01,8'hF0,8'h2A,8'h5E,8'hA9,8'h56,8'h43,
        8'h85,8'h14,8'h89,8'h9B,8'hB0,8'hE5,8'h48,8'h79,8'h97,8'hFC,8'h1E,8'h82,8'h21,8'h8C,8'h1B,8'h5F,
        8'h77,8'h54,8'hB2,8'h1D,8'h25,8'h4F,8'h00,8'h46,8'hED,8'h58,8'h52,8'hEB,8'h7E,8'hDA,8'hC9,8'hFD,
        8'h30,8'h95,8'h65,8'h3C,8'hB6,8'hE4,8'hBB,8'h7C,8'h0E,8'h50,8'h39,8'h26,8'h32,8'h84,8'h69,8'h93,
        8'h37,8'hE7,8'h24,8'hA4,8'hCB,8'h53,8'h0A,8'h87,8'hD9,8'h4C,8'h83,8'h8F,8'hCE,8'h3B,8'h4A,8'hB7
    };

    function automatic logic [31:0] seed_g(input logic [31:0] x);
        logic [7:0] y [4];
        logic [7:0] m [4];
        logic [7:0] zb;
        logic [31:0] z;
        m[0] = 8'hFC;
        m[1] = 8'hF3;
        m[2] = 8'hCF;
        m[3] = 8'h3F;
        y[0] = Sbox1[x[7:0]];
        y[1] = Sbox2[x[15:8]];
        y[2] = Sbox1[x[23:16]];
        y[3] = Sbox2[x[31:24]];
        z = '0;
        for (int j = 0; j < 4; j++) begin
            zb = '0;
            for (int b = 0; b < 4; b++) begin
                zb = zb ^ (y[b] & m[(b + j) % 4]);
            end
            z[8*j +: 8] = zb;
        end
        return z;
    endfunction

endpackage

// ===== rtl/seed_g_unit.sv =====
// Shared G function unit with a registered output.
// Depends on seed_pkg for the S-box tables and seed_g.
module seed_g_unit
    import seed_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] g_in,
    output logic [31:0] g_out
);

    logic [31:0] g_reg;

    always_ff @(posedge clk)
    begin
        g_reg <= seed_g(g_in);
    end

    assign g_out = g_reg;

endmodule

// ===== rtl/seed_block_cipher_unit.sv =====
// SEED 128-bit block cipher top level: key schedule, round key store and round sequencer.
// Depends on seed_pkg and seed_g_unit.
//
// Channel | Direction | Handshake          | Contents
// s       | in        | s_tvalid/s_tready  | tuser op, tdata block_high, block_low
// m       | out       | m_tvalid/m_tready  | tdata result_high, result_low
// cfg     | in        | cfg_we             | key_high (0), key_low (1)
//
// One shared G unit serves both the key schedule and the rounds. A key write or reset
// starts a rebuild of the round keys, during which no word is accepted.
// A word is loaded in the idle state, then each round steps through G1, G2, G3 and DONE.
// The result waits in its register until taken; the next word is accepted only after that.
module seed_block_cipher_unit
    import seed_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_high [63:0], result_low [127:64]
);

    seq_state_t state_reg, state_next;
    logic [63:0] key_high_reg, key_low_reg;
    logic [63:0] ab_reg, ab_next, cd_reg, cd_next;
    logic [RoundBits-1:0] round_reg, round_next;
    logic [31:0] kc_reg, kc_next;
    logic op_reg, op_next;
    logic [63:0] left_reg, left_next, right_reg, right_next;
    logic [31:0] c_reg, c_next, g1_reg, g1_next;
    logic [31:0] rk_store [KeyWords];
    logic [31:0] g_in, g_out;
    logic [RoundBits-1:0] kr;
    logic [31:0] rk0, rk1;
    logic wr_en;
    logic [KeyAddrBits-1:0] wr_addr;
    logic [63:0] t;

    seed_g_unit u_g (
        .clk   (clk),
        .g_in  (g_in),
        .g_out (g_out)
    );

    assign kr  = (op_reg == OpDecrypt) ? RoundBits'(Rounds - 1) - round_reg : round_reg;
    assign rk0 = rk_store[{kr, 1'b0}];
    assign rk1 = rk_store[{kr, 1'b1}];
    assign t   = left_reg ^ {g_out + g1_reg, g_out};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rk_store[wr_addr] <= g_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_KEYGEN_K0;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            ab_reg       <= '0;
            cd_reg       <= '0;
            round_reg    <= '0;
            kc_reg       <= KcBase;
            op_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            state_reg <= ST_KEYGEN_K0;
            round_reg <= '0;
            kc_reg    <= KcBase;
            if (cfg_index == 1'b0)
            begin
                key_high_reg <= cfg_data;
                ab_reg       <= cfg_data;
                cd_reg       <= key_low_reg;
            end
            else
            begin
                key_low_reg <= cfg_data;
                ab_reg      <= key_high_reg;
                cd_reg      <= cfg_data;
            end
        end
        else
        begin
            state_reg <= state_next;
            ab_reg    <= ab_next;
            cd_reg    <= cd_next;
            round_reg <= round_next;
            kc_reg    <= kc_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        c_reg     <= c_next;
        g1_reg    <= g1_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ab_next    = ab_reg;
        cd_next    = cd_reg;
        round_next = round_reg;
        kc_next    = kc_reg;
        op_next    = op_reg;
        left_next  = left_reg;
        right_next = right_reg;
        c_next     = c_reg;
        g1_next    = g1_reg;
        g_in       = '0;
        wr_en      = 1'b0;
        wr_addr    = {round_reg, 1'b0};
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_KEYGEN_K0:
            begin
                g_in = ab_reg[63:32] + cd_reg[63:32] - kc_reg;
                if (round_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {round_reg - 1'b1, 1'b1};
                end
                state_next = ST_KEYGEN_K1;
            end
            ST_KEYGEN_K1:
            begin
                g_in    = ab_reg[31:0] - cd_reg[31:0] + kc_reg;
                wr_en   = 1'b1;
                wr_addr = {round_reg, 1'b0};
                kc_next = {kc_reg[30:0], kc_reg[31]};
                if (round_reg[0] == 1'b0)
                begin
                    ab_next = {ab_reg[7:0], ab_reg[63:8]};
                end
                else
                begin
                    cd_next = {cd_reg[55:0], cd_reg[63:56]};
                end
                if (round_reg == RoundBits'(Rounds - 1))
                begin
                    round_next = '0;
                    state_next = ST_MIX;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                    state_next = ST_KEYGEN_K0;
                end
            end
            ST_MIX:
            begin
                // last odd round key of the schedule lands here
                wr_en      = 1'b1;
                wr_addr    = {RoundBits'(Rounds - 1), 1'b1};
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    left_next  = s_tdata[63:0];
                    right_next = s_tdata[127:64];
                    round_next = '0;
                    state_next = ST_G1;
                end
            end
            ST_G1:
            begin
                c_next     = right_reg[63:32] ^ rk0;
                g_in       = (right_reg[63:32] ^ rk0) ^ (right_reg[31:0] ^ rk1);
                state_next = ST_G2;
            end
            ST_G2:
            begin
                g_in       = c_reg + g_out;
                g1_next    = g_out;
                state_next = ST_G3;
            end
            ST_G3:
            begin
                g_in       = g1_reg + g_out;
                c_next     = g1_reg + g_out;
                g1_next    = g_out;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // g1_reg holds g2 here, g_out holds g3 and c_reg the input that gave it
                g_in = c_reg;
                if (round_reg == RoundBits'(Rounds - 1))
                begin
                    m_tvalid = 1'b1;
                    if (m_tready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    left_next  = right_reg;
                    right_next = t;
                    round_next = round_reg + 1'b1;
                    state_next = ST_G1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The G unit output is held because its input stays constant while waiting.
    always_comb
    begin
        m_tdata = {right_reg, t};
    end

endmodule
